// ----- hw/rtl/yrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared types and constants for the YUV 4:2:0 pixel-pair to RGB converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned TermW = 17;
  localparam int unsigned SumW  = 18;
  localparam int unsigned FracW = 8;

  localparam logic signed [TermW-1:0] COEF_RV = 17'sd358;
  localparam logic signed [TermW-1:0] COEF_GU = 17'sd88;
  localparam logic signed [TermW-1:0] COEF_GV = 17'sd182;
  localparam logic signed [TermW-1:0] COEF_BU = 17'sd453;
  localparam logic [PixW-1:0]         PIX_MAX = 8'd255;

  // chroma products, lumas and change flags after the first stage
  typedef struct packed {
    logic signed [TermW-1:0] r_term;
    logic signed [TermW-1:0] g_term;
    logic signed [TermW-1:0] b_term;
    logic [PixW-1:0]         luma_first;
    logic [PixW-1:0]         luma_second;
    logic                    changed_first;
    logic                    changed_second;
  } chroma_t;

  // unshifted color sums of both pixels
  typedef struct packed {
    logic signed [SumW-1:0] r_first;
    logic signed [SumW-1:0] g_first;
    logic signed [SumW-1:0] b_first;
    logic signed [SumW-1:0] r_second;
    logic signed [SumW-1:0] g_second;
    logic signed [SumW-1:0] b_second;
    logic                   changed_first;
    logic                   changed_second;
  } mix_t;

  // final pixel pair
  typedef struct packed {
    logic [PixW-1:0] red_first;
    logic [PixW-1:0] green_first;
    logic [PixW-1:0] blue_first;
    logic            changed_first;
    logic [PixW-1:0] red_second;
    logic [PixW-1:0] green_second;
    logic [PixW-1:0] blue_second;
    logic            changed_second;
  } pair_t;

endpackage

// ----- hw/rtl/yrgb_chroma.sv -----
// ----------------------------------------------------------------------------
// yrgb_chroma
// Stage 1: chroma offset removal, constant products and change compare.
// ----------------------------------------------------------------------------
module yrgb_chroma (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [7:0]         luma_first_i,
  input  logic [7:0]         luma_second_i,
  input  logic [7:0]         chroma_blue_i,
  input  logic [7:0]         chroma_red_i,
  input  logic [7:0]         prev_luma_first_i,
  input  logic [7:0]         prev_luma_second_i,
  input  logic [7:0]         prev_chroma_blue_i,
  input  logic [7:0]         prev_chroma_red_i,
  output logic               valid_o,
  input  logic               ready_i,
  output yrgb_pkg::chroma_t  data_o
);
  import yrgb_pkg::*;

  logic signed [TermW-1:0] u_x;
  logic signed [TermW-1:0] v_x;
  logic                    chroma_same;
  chroma_t                 data_d;
  chroma_t                 data_q;
  logic                    valid_q;

  // x - 128 on an 8-bit offset-binary code is a flip of the msb
  assign u_x = TermW'($signed({~chroma_blue_i[7], chroma_blue_i[6:0]}));
  assign v_x = TermW'($signed({~chroma_red_i[7], chroma_red_i[6:0]}));

  assign chroma_same = (chroma_blue_i == prev_chroma_blue_i) &&
                       (chroma_red_i == prev_chroma_red_i);

  always_comb begin
    data_d.r_term         = v_x * COEF_RV;
    data_d.g_term         = (u_x * COEF_GU) + (v_x * COEF_GV);
    data_d.b_term         = u_x * COEF_BU;
    data_d.luma_first     = luma_first_i;
    data_d.luma_second    = luma_second_i;
    data_d.changed_first  = !(chroma_same && (luma_first_i == prev_luma_first_i));
    data_d.changed_second = !(chroma_same && (luma_second_i == prev_luma_second_i));
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/yrgb_mix.sv -----
// ----------------------------------------------------------------------------
// yrgb_mix
// Stage 2: adds the shared chroma terms to the scaled luma of each pixel (green subtracts its term).
// ----------------------------------------------------------------------------
module yrgb_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  yrgb_pkg::chroma_t  data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output yrgb_pkg::mix_t     data_o
);
  import yrgb_pkg::*;

  logic signed [SumW-1:0] y0_s;
  logic signed [SumW-1:0] y1_s;
  logic signed [SumW-1:0] r_t;
  logic signed [SumW-1:0] g_t;
  logic signed [SumW-1:0] b_t;
  mix_t                   data_d;
  mix_t                   data_q;
  logic                   valid_q;

  assign y0_s = $signed({2'b00, data_i.luma_first, 8'h00});
  assign y1_s = $signed({2'b00, data_i.luma_second, 8'h00});
  assign r_t  = SumW'(data_i.r_term);
  assign g_t  = SumW'(data_i.g_term);
  assign b_t  = SumW'(data_i.b_term);

  always_comb begin
    data_d.r_first        = y0_s + r_t;
    data_d.g_first        = y0_s - g_t;
    data_d.b_first        = y0_s + b_t;
    data_d.r_second       = y1_s + r_t;
    data_d.g_second       = y1_s - g_t;
    data_d.b_second       = y1_s + b_t;
    data_d.changed_first  = data_i.changed_first;
    data_d.changed_second = data_i.changed_second;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/yrgb_clamp.sv -----
// ----------------------------------------------------------------------------
// yrgb_clamp
// Stage 3: floor shift by 8 and clamp to 0..255; holds the output word.
// ----------------------------------------------------------------------------
module yrgb_clamp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  yrgb_pkg::mix_t   data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output yrgb_pkg::pair_t  data_o
);
  import yrgb_pkg::*;

  pair_t data_d;
  pair_t data_q;
  logic  valid_q;

  function automatic logic [PixW-1:0] clamp_pix(input logic signed [SumW-1:0] sum);
    logic signed [SumW-FracW-1:0] q;
    q = sum[SumW-1:FracW];
    if (q[SumW-FracW-1]) begin
      clamp_pix = '0;
    end else if (q[SumW-FracW-2:PixW] != '0) begin
      clamp_pix = PIX_MAX;
    end else begin
      clamp_pix = q[PixW-1:0];
    end
  endfunction

  always_comb begin
    data_d.red_first      = clamp_pix(data_i.r_first);
    data_d.green_first    = clamp_pix(data_i.g_first);
    data_d.blue_first     = clamp_pix(data_i.b_first);
    data_d.changed_first  = data_i.changed_first;
    data_d.red_second     = clamp_pix(data_i.r_second);
    data_d.green_second   = clamp_pix(data_i.g_second);
    data_d.blue_second    = clamp_pix(data_i.b_second);
    data_d.changed_second = data_i.changed_second;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/yuv420_to_rgb_pair_with_change_skip_top.sv -----
// ----------------------------------------------------------------------------
// yuv420_to_rgb_pair_with_change_skip_top
// Converts a 4:2:0 pixel pair to clamped RGB and flags pixels that differ
// from the previous frame.
//
//   channel | handshake          | word
//   --------+--------------------+----------------------------------------
//   in      | valid_i / stall_o  | luma, chroma and previous-frame samples
//   out     | valid_o / stall_i  | RGB and changed flag of both pixels
//
// One word per cycle while stall_i is low; the word passes three registered
// stages (chroma products, sums, shift and clamp). Reset clears the stage
// valid bits only. Each stage loads whenever it is empty or its successor
// takes its word, so a stall on the output fills bubbles first and reaches
// stall_o only when all three stages hold a word.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_pair_with_change_skip_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] luma_first_i,
  input  logic [7:0] luma_second_i,
  input  logic [7:0] chroma_blue_i,
  input  logic [7:0] chroma_red_i,
  input  logic [7:0] prev_luma_first_i,
  input  logic [7:0] prev_luma_second_i,
  input  logic [7:0] prev_chroma_blue_i,
  input  logic [7:0] prev_chroma_red_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] red_first_o,
  output logic [7:0] green_first_o,
  output logic [7:0] blue_first_o,
  output logic       changed_first_o,
  output logic [7:0] red_second_o,
  output logic [7:0] green_second_o,
  output logic [7:0] blue_second_o,
  output logic       changed_second_o
);
  import yrgb_pkg::*;

  logic    s1_ready;
  logic    s1_valid;
  chroma_t s1_data;
  logic    s2_ready;
  logic    s2_valid;
  mix_t    s2_data;
  logic    s3_ready;
  pair_t   s3_data;

  yrgb_chroma u_chroma (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (valid_i),
    .ready_o            (s1_ready),
    .luma_first_i       (luma_first_i),
    .luma_second_i      (luma_second_i),
    .chroma_blue_i      (chroma_blue_i),
    .chroma_red_i       (chroma_red_i),
    .prev_luma_first_i  (prev_luma_first_i),
    .prev_luma_second_i (prev_luma_second_i),
    .prev_chroma_blue_i (prev_chroma_blue_i),
    .prev_chroma_red_i  (prev_chroma_red_i),
    .valid_o            (s1_valid),
    .ready_i            (s2_ready),
    .data_o             (s1_data)
  );

  yrgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .data_o  (s2_data)
  );

  yrgb_clamp u_clamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .data_i  (s2_data),
    .valid_o (valid_o),
    .ready_i (!stall_i),
    .data_o  (s3_data)
  );

  assign stall_o          = !s1_ready;
  assign red_first_o      = s3_data.red_first;
  assign green_first_o    = s3_data.green_first;
  assign blue_first_o     = s3_data.blue_first;
  assign changed_first_o  = s3_data.changed_first;
  assign red_second_o     = s3_data.red_second;
  assign green_second_o   = s3_data.green_second;
  assign blue_second_o    = s3_data.blue_second;
  assign changed_second_o = s3_data.changed_second;

endmodule
